FILE: hdl/bdar_pkg.sv
`timescale 1ns / 1ps

package bdar_pkg;

    // Register reset values
    localparam logic [31:0] DEBOUNCE_THRESHOLD_RST = 32'd10000;
    localparam logic [31:0] HOLD_DELAY_RST         = 32'd330000;
    localparam logic [3:0]  ACCEL_AFTER_RST        = 4'd10;
    localparam logic [2:0]  FAST_MULTIPLIER_RST    = 3'd3;

    // Button bit positions in a sample
    localparam int BTN_RIGHT = 0;
    localparam int BTN_MID   = 1;
    localparam int BTN_LEFT  = 2;

    // First hold level at which a held button repeats
    localparam logic [3:0] HOLD_REPEAT_LEVEL = 4'd3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEBOUNCE_THRESHOLD = 2'd0,
        REG_HOLD_DELAY         = 2'd1,
        REG_ACCEL_AFTER        = 2'd2,
        REG_FAST_MULTIPLIER    = 2'd3
    } reg_index_t;

    // Result word kinds
    typedef enum logic {
        EV_STEP = 1'b0,
        EV_MODE = 1'b1
    } event_kind_t;

    typedef struct packed {
        logic [31:0] debounce_threshold;
        logic [31:0] hold_delay;
        logic [3:0]  accel_after;
        logic [2:0]  fast_multiplier;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        event_kind_t        kind;
        logic signed [3:0]  step;
    } result_t;

endpackage

FILE: hdl/bdar_core.sv
`timescale 1ns / 1ps

// Debounce and auto-repeat state; one sample processed per fire.
module bdar_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [2:0]       buttons,
    input  logic [15:0]      elapsed,
    input  bdar_pkg::cfg_t   cfg,
    output bdar_pkg::result_t result
);

    logic [2:0]  prev_reg, prev_next;
    logic [2:0]  stable_reg, stable_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  hold_reg, hold_next;

    logic [32:0] sum;
    logic [31:0] acc_sat;
    logic [31:0] acc_v;
    logic [3:0]  hold_v;
    logic        changed;
    logic [2:0]  rise;
    logic [2:0]  mag;

    // Saturating tick sum, then debounce / hold decisions
    always_comb
    begin
        prev_next   = buttons;
        stable_next = stable_reg;
        acc_next    = acc_reg;
        hold_next   = hold_reg;
        result      = '0;
        mag         = 3'd1;
        rise        = buttons & ~stable_reg;

        sum     = {1'b0, acc_reg} + {17'b0, elapsed};
        acc_sat = sum[32] ? '1 : sum[31:0];
        changed = (buttons != prev_reg);
        acc_v   = changed ? '0 : acc_sat;
        hold_v  = changed ? '0 : hold_reg;

        if (hold_v == 4'd0)
        begin
            acc_next  = acc_v;
            hold_next = 4'd0;
            if (acc_v > cfg.debounce_threshold)
            begin
                stable_next = buttons;
                acc_next    = '0;
                if (rise[bdar_pkg::BTN_RIGHT])
                begin
                    hold_next    = 4'd1;
                    result.valid = 1'b1;
                    result.kind  = bdar_pkg::EV_STEP;
                    result.step  = -4'sd1;
                end
                else if (rise[bdar_pkg::BTN_MID])
                begin
                    result.valid = 1'b1;
                    result.kind  = bdar_pkg::EV_MODE;
                    result.step  = 4'sd0;
                end
                else if (rise[bdar_pkg::BTN_LEFT])
                begin
                    hold_next    = 4'd1;
                    result.valid = 1'b1;
                    result.kind  = bdar_pkg::EV_STEP;
                    result.step  = 4'sd1;
                end
            end
        end
        else if (acc_v > cfg.hold_delay)
        begin
            acc_next = '0;
            if (hold_v < bdar_pkg::HOLD_REPEAT_LEVEL)
            begin
                hold_next = 4'(hold_v + 4'd1);
            end
            else
            begin
                // slow repeats advance the level, fast ones keep it
                if (hold_v < cfg.accel_after)
                begin
                    mag       = 3'd1;
                    hold_next = 4'(hold_v + 4'd1);
                end
                else
                begin
                    mag       = cfg.fast_multiplier;
                    hold_next = hold_v;
                end
                if (buttons[bdar_pkg::BTN_RIGHT])
                begin
                    result.valid = 1'b1;
                    result.kind  = bdar_pkg::EV_STEP;
                    result.step  = $signed(4'd0 - {1'b0, mag});
                end
                else if (buttons[bdar_pkg::BTN_LEFT])
                begin
                    result.valid = 1'b1;
                    result.kind  = bdar_pkg::EV_STEP;
                    result.step  = $signed({1'b0, mag});
                end
            end
        end
        else
        begin
            acc_next  = acc_v;
            hold_next = hold_v;
        end
    end

    // State registers, advanced once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            stable_reg <= '0;
            acc_reg    <= '0;
            hold_reg   <= '0;
        end
        else if (fire)
        begin
            prev_reg   <= prev_next;
            stable_reg <= stable_next;
            acc_reg    <= acc_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

FILE: hdl/button_debounce_auto_repeat.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// in        in_valid / in_ready       buttons[2:0], elapsed[15:0]
// out       out_valid / out_ready     event_kind, step_amount[3:0] signed
// cfg       cfg_write (no handshake)  cfg_index[1:0], cfg_data[31:0]
//
// One word per cycle unless the output stalls: a word is held in the input
// register, the state update and result decision run in a single pass, and
// the result, if any, lands in the output register and raises out_valid.
// While a result waits in the output register and out_ready is low, a word
// in the input register stays and in_ready drops; a taken result frees the
// output register for the next word in the same cycle. Reset clears the
// valid flags and debounce state and loads the default register values.
module button_debounce_auto_repeat
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        buttons,
    input  logic [15:0]       elapsed,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              event_kind,
    output logic signed [3:0] step_amount,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    bdar_pkg::cfg_t    cfg_reg;
    bdar_pkg::result_t core_result;

    logic              stage_valid_reg;
    logic [2:0]        buttons_reg;
    logic [15:0]       elapsed_reg;
    logic              out_valid_reg;
    logic              kind_reg;
    logic signed [3:0] step_reg;
    logic              advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_threshold <= bdar_pkg::DEBOUNCE_THRESHOLD_RST;
            cfg_reg.hold_delay         <= bdar_pkg::HOLD_DELAY_RST;
            cfg_reg.accel_after        <= bdar_pkg::ACCEL_AFTER_RST;
            cfg_reg.fast_multiplier    <= bdar_pkg::FAST_MULTIPLIER_RST;
        end
        else if (cfg_write)
        begin
            unique case (bdar_pkg::reg_index_t'(cfg_index))
                bdar_pkg::REG_DEBOUNCE_THRESHOLD: cfg_reg.debounce_threshold <= cfg_data;
                bdar_pkg::REG_HOLD_DELAY:         cfg_reg.hold_delay         <= cfg_data;
                bdar_pkg::REG_ACCEL_AFTER:        cfg_reg.accel_after        <= cfg_data[3:0];
                bdar_pkg::REG_FAST_MULTIPLIER:    cfg_reg.fast_multiplier    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Stage moves when its result has a free output slot
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            buttons_reg <= buttons;
            elapsed_reg <= elapsed;
        end
    end

    bdar_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .buttons (buttons_reg),
        .elapsed (elapsed_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && core_result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_result.valid)
        begin
            kind_reg <= core_result.kind;
            step_reg <= core_result.step;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign step_amount = step_reg;

`ifndef NO_ASSERTIONS
    // A mode word never carries a step
    a_mode_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == bdar_pkg::EV_MODE) |-> (step_reg == 4'sd0))
        else $error("mode word with nonzero step");

    // A blocked stage keeps its word
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> stage_valid_reg)
        else $error("stage word dropped while blocked");

    // An accepted word always reaches the stage
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> stage_valid_reg)
        else $error("accepted word lost");

    // A waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("stage advanced into a full output register");
`endif

endmodule

FILE: dv/button_debounce_auto_repeat_test.sv
`timescale 1ns / 1ps

module button_debounce_auto_repeat_test;

    // Button masks for a sample
    localparam logic [2:0] PRESS_NONE  = 3'b000;
    localparam logic [2:0] PRESS_RIGHT = 3'(1 << bdar_pkg::BTN_RIGHT);
    localparam logic [2:0] PRESS_MID   = 3'(1 << bdar_pkg::BTN_MID);
    localparam logic [2:0] PRESS_LEFT  = 3'(1 << bdar_pkg::BTN_LEFT);
    localparam logic [2:0] PRESS_ALL   = PRESS_RIGHT | PRESS_MID | PRESS_LEFT;

    typedef struct {
        bdar_pkg::event_kind_t kind;
        logic signed [3:0]     step;
    } button_event_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        buttons;
    logic [15:0]       elapsed;
    logic              out_valid;
    logic              out_ready;
    logic              event_kind;
    logic signed [3:0] step_amount;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;

    // Shadow of the block's registers and debounce state
    bdar_pkg::cfg_t cfg_shadow;
    logic [2:0] last_sample;
    logic [2:0] stable_buttons;
    logic [31:0] tick_acc;
    logic [3:0] hold_level;

    button_event_t pending_events[$];
    int            error_count;
    int            words_sent;
    int            holdoff_request;
    bit            idle_on;

    button_debounce_auto_repeat dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .buttons     (buttons),
        .elapsed     (elapsed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .step_amount (step_amount),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("button_debounce_auto_repeat_test: errors");
        $finish;
    end

    // Advance the debounce state by one sample, queue the event it causes
    function automatic void debounce_step(input logic [2:0] smp, input logic [15:0] ticks);
        logic [32:0]       sum;
        logic [2:0]        rise;
        logic [2:0]        mag;
        logic signed [3:0] amount;
        sum = {1'b0, tick_acc} + {17'd0, ticks};
        tick_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (smp != last_sample)
        begin
            tick_acc = '0;
            hold_level = '0;
        end
        last_sample = smp;

        if (hold_level == 4'd0)
        begin
            if (tick_acc > cfg_shadow.debounce_threshold)
            begin
                rise = smp & ~stable_buttons;
                stable_buttons = smp;
                tick_acc = '0;
                // right beats mid beats left
                if (rise[bdar_pkg::BTN_RIGHT])
                begin
                    hold_level = 4'd1;
                    pending_events.push_back('{kind: bdar_pkg::EV_STEP, step: -4'sd1});
                end
                else if (rise[bdar_pkg::BTN_MID])
                    pending_events.push_back('{kind: bdar_pkg::EV_MODE, step: 4'sd0});
                else if (rise[bdar_pkg::BTN_LEFT])
                begin
                    hold_level = 4'd1;
                    pending_events.push_back('{kind: bdar_pkg::EV_STEP, step: 4'sd1});
                end
            end
        end
        else if (tick_acc > cfg_shadow.hold_delay)
        begin
            tick_acc = '0;
            if (hold_level < bdar_pkg::HOLD_REPEAT_LEVEL)
                hold_level = hold_level + 4'd1;
            else
            begin
                if (hold_level < cfg_shadow.accel_after)
                begin
                    mag = 3'd1;
                    hold_level = hold_level + 4'd1;
                end
                else
                    mag = cfg_shadow.fast_multiplier;
                amount = {1'b0, mag};
                if (smp[bdar_pkg::BTN_RIGHT])
                    pending_events.push_back('{kind: bdar_pkg::EV_STEP, step: -amount});
                else if (smp[bdar_pkg::BTN_LEFT])
                    pending_events.push_back('{kind: bdar_pkg::EV_STEP, step: amount});
            end
        end
    endfunction

    // Offer one sample word; valid stays high after acceptance
    task automatic offer_sample(input logic [2:0] pattern, input logic [15:0] ticks);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        buttons  <= pattern;
        elapsed  <= ticks;
        do
            @(posedge clk);
        while (!in_ready);
        debounce_step(pattern, ticks);
        words_sent++;
    endtask

    task automatic press(input logic [2:0] pattern, input int count, input logic [15:0] ticks);
        repeat (count) offer_sample(pattern, ticks);
    endtask

    // Stop offering and let every expected word come out
    task automatic wait_for_events();
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers; block must be idle
    task automatic set_config(input logic [31:0] threshold, input logic [31:0] delay,
                              input logic [3:0] accel, input logic [2:0] mult);
        cfg_write <= 1'b1;
        cfg_index <= bdar_pkg::REG_DEBOUNCE_THRESHOLD;
        cfg_data  <= threshold;
        @(posedge clk);
        cfg_index <= bdar_pkg::REG_HOLD_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        cfg_index <= bdar_pkg::REG_ACCEL_AFTER;
        cfg_data  <= {28'd0, accel};
        @(posedge clk);
        cfg_index <= bdar_pkg::REG_FAST_MULTIPLIER;
        cfg_data  <= {29'd0, mult};
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_shadow.debounce_threshold = threshold;
        cfg_shadow.hold_delay         = delay;
        cfg_shadow.accel_after        = accel;
        cfg_shadow.fast_multiplier    = mult;
    endtask

    // Result checker with random stalls and long hold-offs
    initial
    begin : result_monitor
        int            stall_left;
        int            holdoff_left;
        button_event_t want;
        stall_left   = 0;
        holdoff_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("unexpected word: event_kind %0d step_amount %0d",
                           event_kind, step_amount);
                    error_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind)
                    begin
                        $error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
                        error_count++;
                    end
                    if (step_amount !== want.step)
                    begin
                        $error("step_amount: expected %0d, actual %0d", want.step, step_amount);
                        error_count++;
                    end
                end
                stall_left = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (holdoff_request > 0)
            begin
                holdoff_left = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Default registers: left press, then one repeat after two silent stages
    task automatic test_reset_values();
        press(PRESS_LEFT, 1, 16'hFFFF);
        press(PRESS_LEFT, 1, 16'd10000);
        press(PRESS_LEFT, 1, 16'd1);
        press(PRESS_LEFT, 18, 16'hFFFF);
        press(PRESS_NONE, 1, 16'd0);
        press(PRESS_NONE, 1, 16'd10001);
        wait_for_events();
    endtask

    // Each button, priority, debounce with no edge, right winning a repeat
    task automatic test_edges();
        set_config(32'd100, 32'd200, 4'd4, 3'd7);
        press(PRESS_RIGHT, 3, 16'd60);
        press(PRESS_NONE, 3, 16'd60);
        press(PRESS_MID, 3, 16'd60);
        press(PRESS_NONE, 3, 16'd60);
        press(PRESS_ALL, 3, 16'd60);
        press(PRESS_ALL, 6, 16'd201);
        // right already stable: no edge on this change
        press(PRESS_RIGHT, 3, 16'd60);
        // left edge starts a hold, repeats go right
        press(PRESS_RIGHT | PRESS_LEFT, 3, 16'd60);
        press(PRESS_RIGHT | PRESS_LEFT, 4, 16'd201);
        press(PRESS_NONE, 3, 16'd60);
        press(PRESS_LEFT, 4, 16'd0);
        press(PRESS_LEFT, 2, 16'hFFFF);
        press(PRESS_NONE, 2, 16'hFFFF);
        wait_for_events();
    endtask

    // Acceleration: slow repeats up to the top level, then fast ones
    task automatic test_accel();
        set_config(32'd0, 32'd0, 4'd15, 3'd7);
        press(PRESS_LEFT, 21, 16'd1);
        press(PRESS_NONE, 2, 16'd1);
        wait_for_events();
        // fast from the first repeat with a zero step
        set_config(32'd0, 32'd0, 4'd0, 3'd0);
        press(PRESS_RIGHT, 7, 16'd1);
        press(PRESS_NONE, 2, 16'd1);
        wait_for_events();
        set_config(32'd5, 32'd5, 4'd3, 3'd1);
        press(PRESS_LEFT, 9, 16'd3);
        press(PRESS_NONE, 3, 16'd3);
        wait_for_events();
    endtask

    // Wide thresholds: many full-range samples summed before each decision
    task automatic test_long_count();
        set_config(32'h000F_FFFF, 32'h0002_0000, 4'd4, 3'd5);
        press(PRESS_LEFT, 30, 16'hFFFF);
        press(PRESS_NONE, 2, 16'hFFFF);
        wait_for_events();
    endtask

    // Output blocked long enough to back the block up, then a no-idle burst
    task automatic test_backpressure();
        set_config(32'd0, 32'd0, 4'd15, 3'd7);
        holdoff_request = 300;
        press(PRESS_LEFT, 60, 16'd1);
        wait_for_events();
        press(PRESS_NONE, 2, 16'd1);
        idle_on = 1'b0;
        press(PRESS_RIGHT, 40, 16'd1);
        press(PRESS_NONE, 2, 16'd1);
        wait_for_events();
        idle_on = 1'b1;
    endtask

    // Mostly held presses with random timing, some noise words
    task automatic run_phase(input int count, input int span);
        int         target;
        int         pick;
        int         len;
        logic [2:0] pattern;
        target = words_sent + count;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       pattern = PRESS_RIGHT;
                    1:       pattern = PRESS_MID;
                    2:       pattern = PRESS_LEFT;
                    default: pattern = 3'($urandom_range(1, 7));
                endcase
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(2, 20);
                repeat (len) offer_sample(pattern, 16'($urandom_range(0, span)));
                if ($urandom_range(0, 3) != 0)
                    repeat ($urandom_range(1, 6))
                        offer_sample(PRESS_NONE, 16'($urandom_range(0, span)));
            end
            else
                repeat ($urandom_range(1, 8)) offer_sample(3'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random();
        logic [31:0] threshold;
        logic [31:0] delay;
        logic [3:0]  accel;
        logic [2:0]  mult;
        int          count;
        for (int p = 0; p < 8; p++)
        begin
            threshold = $urandom_range(0, 3000);
            delay     = $urandom_range(0, 6000);
            accel     = 4'($urandom_range(0, 15));
            mult      = 3'($urandom_range(0, 7));
            count     = 140;
            case (p)
                0:
                begin
                    threshold = 32'd0;
                    delay     = 32'd0;
                    accel     = 4'd15;
                    mult      = 3'd7;
                end
                1:
                begin
                    threshold = 32'hFFFF_FFFF;
                    accel     = 4'd3;
                    mult      = 3'd1;
                    count     = 40;
                end
                2:
                begin
                    delay = 32'hFFFF_FFFF;
                    accel = 4'd0;
                    mult  = 3'd0;
                end
                4:
                begin
                    threshold = $urandom;
                    delay     = $urandom_range(0, 2000);
                end
                default: ;
            endcase
            wait_for_events();
            idle_on = (p != 3);
            set_config(threshold, delay, accel, mult);
            run_phase(count, int'($urandom_range(200, 3000)));
        end
        wait_for_events();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        buttons   <= '0;
        elapsed   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= bdar_pkg::REG_DEBOUNCE_THRESHOLD;
        cfg_data  <= '0;
        cfg_shadow.debounce_threshold = bdar_pkg::DEBOUNCE_THRESHOLD_RST;
        cfg_shadow.hold_delay         = bdar_pkg::HOLD_DELAY_RST;
        cfg_shadow.accel_after        = bdar_pkg::ACCEL_AFTER_RST;
        cfg_shadow.fast_multiplier    = bdar_pkg::FAST_MULTIPLIER_RST;
        last_sample     = '0;
        stable_buttons  = '0;
        tick_acc        = '0;
        hold_level      = '0;
        error_count     = 0;
        words_sent      = 0;
        holdoff_request = 0;
        idle_on         = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_edges();
        test_accel();
        test_long_count();
        test_backpressure();
        test_random();

        wait_for_events();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("button_debounce_auto_repeat_test: clean");
        else
            $display("button_debounce_auto_repeat_test: errors");
        $finish;
    end

endmodule
